[rtl/multimode_sample_filter_defines.svh]
// Assertion macros shared by the multimode sample filter RTL.
`ifndef MULTIMODE_SAMPLE_FILTER_DEFINES_SVH
`define MULTIMODE_SAMPLE_FILTER_DEFINES_SVH

// Same-cycle implication check, disabled while reset is asserted.
`define MSF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled while reset is asserted.
`define MSF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/msf_pkg.sv]
// Shared types, codes and the per-mode microprogram of the sample filter.
`default_nettype none
package msf_pkg;

  // Internal number formats.
  localparam int HW      = 48;
  localparam int HALF_W  = HW / 2;
  localparam int ACC_W   = 51;
  localparam int EXT_FRAC = 12;
  localparam int WFRAC   = 16;
  localparam int CFG_W   = 32;
  localparam int MODE_W  = 4;
  localparam int IDX_W   = 3;
  localparam int WGT_W   = 17;
  localparam int STEP_W  = 5;
  localparam logic [WGT_W-1:0] W_ONE = 17'h10000;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_NONE  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_PT1   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_LPF   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_NOTCH = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BPF   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DF1   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_FIR2  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MED3  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_PT2   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_PT3   = 4'd9;
  localparam logic [MODE_W-1:0] MODE_FO    = 4'd10;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] IDX_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_B0     = 3'd1;
  localparam logic [IDX_W-1:0] IDX_B1     = 3'd2;
  localparam logic [IDX_W-1:0] IDX_B2     = 3'd3;
  localparam logic [IDX_W-1:0] IDX_A1     = 3'd4;
  localparam logic [IDX_W-1:0] IDX_A2     = 3'd5;
  localparam logic [IDX_W-1:0] IDX_WEIGHT = 3'd6;

  // Micro-operations.
  localparam logic [3:0] OP_END  = 4'd0;
  localparam logic [3:0] OP_LD   = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MACA = 4'd4;
  localparam logic [3:0] OP_MACS = 4'd5;
  localparam logic [3:0] OP_ST   = 4'd6;
  localparam logic [3:0] OP_MOV  = 4'd7;
  localparam logic [3:0] OP_HALF = 4'd8;
  localparam logic [3:0] OP_MED  = 4'd9;

  // Operand sources.
  localparam logic [2:0] SRC_ZERO = 3'd0;
  localparam logic [2:0] SRC_N    = 3'd1;
  localparam logic [2:0] SRC_R    = 3'd2;
  localparam logic [2:0] SRC_D    = 3'd3;
  localparam logic [2:0] SRC_H0   = 3'd4;
  localparam logic [2:0] SRC_H1   = 3'd5;
  localparam logic [2:0] SRC_H2   = 3'd6;
  localparam logic [2:0] SRC_H3   = 3'd7;

  // Destinations.
  localparam logic [2:0] DST_R  = 3'd0;
  localparam logic [2:0] DST_D  = 3'd1;
  localparam logic [2:0] DST_H0 = 3'd2;
  localparam logic [2:0] DST_H1 = 3'd3;
  localparam logic [2:0] DST_H2 = 3'd4;
  localparam logic [2:0] DST_H3 = 3'd5;

  // Multiplier coefficient selects.
  localparam logic [2:0] B_B0 = 3'd0;
  localparam logic [2:0] B_B1 = 3'd1;
  localparam logic [2:0] B_B2 = 3'd2;
  localparam logic [2:0] B_A1 = 3'd3;
  localparam logic [2:0] B_A2 = 3'd4;
  localparam logic [2:0] B_W  = 3'd5;
  localparam logic [2:0] B_WC = 3'd6;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] src;
    logic [2:0] dst;
    logic [2:0] bsel;
  } uop_t;

  typedef struct packed {
    logic n_load;
    logic exec;
    logic mul_start;
    logic mac_apply;
    logic out_load;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
  } sts_t;

  function automatic uop_t mk(input logic [3:0] op, input logic [2:0] src,
                              input logic [2:0] dst, input logic [2:0] bsel);
    uop_t u;
    u.op   = op;
    u.src  = src;
    u.dst  = dst;
    u.bsel = bsel;
    return u;
  endfunction

  function automatic logic [2:0] src_h(input logic [1:0] i);
    return {1'b1, i};
  endfunction

  function automatic logic [2:0] dst_h(input logic [1:0] i);
    return DST_H0 + {1'b0, i};
  endfunction

  // One smoother stage: d = src - v; v = v + k*d.
  function automatic uop_t pt_uop(input logic [1:0] stg, input logic [2:0] sub);
    uop_t u;
    u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
    case (sub)
      3'd0: u = mk(OP_LD, (stg == 2'd0) ? SRC_N : src_h(stg - 2'd1), DST_R, B_B0);
      3'd1: u = mk(OP_SUB, src_h(stg), DST_R, B_B0);
      3'd2: u = mk(OP_ST, SRC_ZERO, DST_D, B_B0);
      3'd3: u = mk(OP_LD, src_h(stg), DST_R, B_B0);
      3'd4: u = mk(OP_MACA, SRC_D, DST_R, B_B0);
      3'd5: u = mk(OP_ST, SRC_ZERO, dst_h(stg), B_B0);
      default: u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
    endcase
    return u;
  endfunction

  // Microprogram: the operation at a given step of a given mode.
  function automatic uop_t ucode(input logic [MODE_W-1:0] mode,
                                 input logic [STEP_W-1:0] step);
    uop_t u;
    logic [1:0] nst;
    logic [STEP_W-1:0] base;
    logic [STEP_W-1:0] sub;
    logic [1:0] stg;
    u    = mk(OP_END, SRC_ZERO, DST_R, B_B0);
    nst  = 2'd1;
    base = '0;
    sub  = '0;
    stg  = 2'd0;
    unique case (mode) inside
      MODE_PT1, MODE_PT2, MODE_PT3: begin
        nst  = (mode == MODE_PT1) ? 2'd1 : ((mode == MODE_PT2) ? 2'd2 : 2'd3);
        base = {1'b0, nst, 2'b00} + {2'b00, nst, 1'b0};
        if (step < 5'd6) begin
          stg = 2'd0;
          sub = step;
        end else if (step < 5'd12) begin
          stg = 2'd1;
          sub = step - 5'd6;
        end else begin
          stg = 2'd2;
          sub = step - 5'd12;
        end
        if (step < base) begin
          u = pt_uop(stg, sub[2:0]);
        end else if (step == base) begin
          u = mk(OP_MOV, src_h(nst - 2'd1), DST_R, B_B0);
        end
      end
      MODE_LPF, MODE_NOTCH, MODE_BPF: begin
        case (step)
          5'd0:  u = mk(OP_LD, SRC_H0, DST_R, B_B0);
          5'd1:  u = mk(OP_MACA, SRC_N, DST_R, B_B0);
          5'd2:  u = mk(OP_ST, SRC_ZERO, DST_R, B_B0);
          5'd3:  u = mk(OP_LD, SRC_H1, DST_R, B_B0);
          5'd4:  u = mk(OP_MACA, SRC_N, DST_R, B_B1);
          5'd5:  u = mk(OP_MACS, SRC_R, DST_R, B_A1);
          5'd6:  u = mk(OP_ST, SRC_ZERO, DST_H0, B_B0);
          5'd7:  u = mk(OP_LD, SRC_ZERO, DST_R, B_B0);
          5'd8:  u = mk(OP_MACA, SRC_N, DST_R, B_B2);
          5'd9:  u = mk(OP_MACS, SRC_R, DST_R, B_A2);
          5'd10: u = mk(OP_ST, SRC_ZERO, DST_H1, B_B0);
          default: u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
        endcase
      end
      MODE_FO: begin
        case (step)
          5'd0: u = mk(OP_LD, SRC_H0, DST_R, B_B0);
          5'd1: u = mk(OP_MACA, SRC_N, DST_R, B_B0);
          5'd2: u = mk(OP_ST, SRC_ZERO, DST_R, B_B0);
          5'd3: u = mk(OP_LD, SRC_ZERO, DST_R, B_B0);
          5'd4: u = mk(OP_MACA, SRC_N, DST_R, B_B1);
          5'd5: u = mk(OP_MACS, SRC_R, DST_R, B_A1);
          5'd6: u = mk(OP_ST, SRC_ZERO, DST_H0, B_B0);
          default: u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
        endcase
      end
      MODE_DF1: begin
        case (step)
          5'd0:  u = mk(OP_LD, SRC_ZERO, DST_R, B_B0);
          5'd1:  u = mk(OP_MACA, SRC_N, DST_R, B_B0);
          5'd2:  u = mk(OP_MACA, SRC_H0, DST_R, B_B1);
          5'd3:  u = mk(OP_MACA, SRC_H1, DST_R, B_B2);
          5'd4:  u = mk(OP_MACS, SRC_H2, DST_R, B_A1);
          5'd5:  u = mk(OP_MACS, SRC_H3, DST_R, B_A2);
          5'd6:  u = mk(OP_ST, SRC_ZERO, DST_R, B_B0);
          5'd7:  u = mk(OP_MOV, SRC_H0, DST_H1, B_B0);
          5'd8:  u = mk(OP_MOV, SRC_N, DST_H0, B_B0);
          5'd9:  u = mk(OP_MOV, SRC_H2, DST_H3, B_B0);
          5'd10: u = mk(OP_MOV, SRC_R, DST_H2, B_B0);
          5'd11: u = mk(OP_LD, SRC_ZERO, DST_R, B_B0);
          5'd12: u = mk(OP_MACA, SRC_R, DST_R, B_W);
          5'd13: u = mk(OP_MACA, SRC_N, DST_R, B_WC);
          5'd14: u = mk(OP_ST, SRC_ZERO, DST_R, B_B0);
          default: u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
        endcase
      end
      MODE_FIR2: begin
        case (step)
          5'd0: u = mk(OP_LD, SRC_N, DST_R, B_B0);
          5'd1: u = mk(OP_ADD, SRC_H0, DST_R, B_B0);
          5'd2: u = mk(OP_HALF, SRC_ZERO, DST_R, B_B0);
          5'd3: u = mk(OP_ST, SRC_ZERO, DST_R, B_B0);
          5'd4: u = mk(OP_MOV, SRC_N, DST_H0, B_B0);
          default: u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
        endcase
      end
      MODE_MED3: begin
        case (step)
          5'd0: u = mk(OP_MED, SRC_ZERO, DST_R, B_B0);
          5'd1: u = mk(OP_MOV, SRC_H1, DST_H0, B_B0);
          5'd2: u = mk(OP_MOV, SRC_N, DST_H1, B_B0);
          default: u = mk(OP_END, SRC_ZERO, DST_R, B_B0);
        endcase
      end
      default: begin
        // Pass-through, also for the unused mode codes.
        if (step == 5'd0) begin
          u = mk(OP_MOV, SRC_N, DST_R, B_B0);
        end
      end
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

[rtl/multimode_sample_filter.sv]
// Top level of the multimode sample filter: controller plus datapath.
//
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_stall    in_sample_in (signed sample)
//  out_      output     out_valid/out_stall  out_sample_out (signed sample)
//  cfg_      input      cfg_we               cfg_index, cfg_data
//
// Each transaction is worked as a short microprogram of steps; every product
// is formed on the one shared 24x32 multiplier, and the sequencer waits for it.
// Reset clears mode, coefficients, history and the output register valid.
// A new input is taken while the previous result waits on out_stall; the
// sequencer only holds at its last step if the output register is still full.
`default_nettype none
`include "multimode_sample_filter_defines.svh"
module multimode_sample_filter #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [msf_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [msf_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out
);
  import msf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  msf_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_sample_out (out_sample_out)
  );

  // Design checks.
  `MSF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")
  `MSF_ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_load, !(out_valid && out_stall), "output overwritten")
  `MSF_ASSERT_IMP(a_mul_start_idle, clk, rst_n, cmd.mul_start, !sts.mul_busy, "multiplier restarted")
  `MSF_ASSERT_IMP(a_done_applied, clk, rst_n, sts.mul_done, cmd.mac_apply, "product dropped")

endmodule
`default_nettype wire

[rtl/msf_mul.sv]
// Shared rounding multiplier: 48-bit sample by 32-bit coefficient, two 24-bit halves.
`default_nettype none
module msf_mul #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          wfrac,
  input  wire logic signed [msf_pkg::HW-1:0] a_in,
  input  wire logic signed [msf_pkg::CFG_W-1:0] b_in,
  output logic                               busy,
  output logic                               done,
  output logic signed [msf_pkg::HW-1:0]      prod
);
  import msf_pkg::*;

  localparam int PROD_W = HALF_W + CFG_W;
  localparam int SUM_W  = HW + CFG_W;
  localparam logic [SUM_W-1:0] RND_C = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] RND_W = SUM_W'(1) << (WFRAC - 1);
  localparam logic [HW-1:0] LIM_POS = {1'b0, {(HW-1){1'b1}}};
  localparam logic [HW-1:0] LIM_NEG = {1'b1, {(HW-1){1'b0}}};

  logic [2:0]        phase_r;
  logic              done_r;
  logic [HW-1:0]     ua_r;
  logic [CFG_W-1:0]  ub_r;
  logic              neg_r;
  logic              wfrac_r;
  logic [PROD_W-1:0] p_lo_r;
  logic [PROD_W-1:0] p_hi_r;
  logic [SUM_W-1:0]  sum_r;
  logic signed [HW-1:0] prod_r;

  logic [HALF_W-1:0] half;
  logic [PROD_W-1:0] mul_o;
  logic [SUM_W-1:0]  q;
  logic [HW-1:0]     lim;
  logic [HW-1:0]     mag;

  // One 24x32 multiplier serves both halves of the sample.
  assign half  = (phase_r == 3'd1) ? ua_r[HALF_W-1:0] : ua_r[HW-1:HALF_W];
  assign mul_o = PROD_W'(half) * PROD_W'(ub_r);

  // Scale, saturate the magnitude and restore the sign.
  assign q    = wfrac_r ? (sum_r >> WFRAC) : (sum_r >> COEF_FRAC_BITS);
  assign lim  = neg_r ? LIM_NEG : LIM_POS;
  assign mag  = (q > SUM_W'(lim)) ? lim : q[HW-1:0];

  // Sequencing of the partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == 3'd4);
      if (start) begin
        phase_r <= 3'd1;
      end else if (phase_r == 3'd4) begin
        phase_r <= 3'd0;
      end else if (phase_r != 3'd0) begin
        phase_r <= phase_r + 3'd1;
      end
    end
  end

  // Operand and partial product registers.
  always_ff @(posedge clk) begin
    if (start) begin
      ua_r    <= a_in[HW-1] ? (HW'(0) - a_in) : a_in;
      ub_r    <= b_in[CFG_W-1] ? (CFG_W'(0) - b_in) : b_in;
      neg_r   <= a_in[HW-1] ^ b_in[CFG_W-1];
      wfrac_r <= wfrac;
    end
    if (phase_r == 3'd1) begin
      p_lo_r <= mul_o;
    end
    if (phase_r == 3'd2) begin
      p_hi_r <= mul_o;
    end
    if (phase_r == 3'd3) begin
      sum_r <= {p_hi_r, {HALF_W{1'b0}}} + SUM_W'(p_lo_r) + (wfrac_r ? RND_W : RND_C);
    end
    if (phase_r == 3'd4) begin
      prod_r <= neg_r ? (HW'(0) - mag) : mag;
    end
  end

  assign busy = (phase_r != 3'd0) || done_r;
  assign done = done_r;
  assign prod = prod_r;

endmodule
`default_nettype wire

[rtl/msf_dp.sv]
// Datapath: coefficient registers, history, accumulator and output register.
`default_nettype none
module msf_dp #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [msf_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [msf_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  input  wire msf_pkg::cmd_t                    cmd,
  output msf_pkg::sts_t                         sts,
  output logic signed [SAMPLE_WIDTH-1:0]        out_sample_out
);
  import msf_pkg::*;

  localparam int TW = HW - EXT_FRAC + 1;
  localparam logic signed [ACC_W-1:0] AMAX = {{(ACC_W-HW+1){1'b0}}, {(HW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] AMIN = ~AMAX;
  localparam logic signed [TW-1:0] SMAX = {{(TW-SAMPLE_WIDTH+1){1'b0}},
                                           {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [TW-1:0] SMIN = ~SMAX;
  localparam logic signed [HW:0] ORND = (HW+1)'(1) << (EXT_FRAC - 1);

  // Configuration registers.
  logic signed [CFG_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [WGT_W-1:0]        weight_r;

  // Working registers.
  logic signed [HW-1:0]    n_r, r_r, d_r;
  logic signed [HW-1:0]    h_r [4];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic signed [HW-1:0]    n_ext;
  logic signed [HW-1:0]    src_val;
  logic signed [CFG_W-1:0] b_val;
  logic [WGT_W-1:0]        w_eff;
  logic signed [ACC_W-1:0] acc_src;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [HW-1:0]    acc_sat;
  logic signed [HW-1:0]    lo_v, hi_v, mid_v, med_v;
  logic                    wr_en;
  logic signed [HW-1:0]    wr_val;
  logic signed [HW:0]      o_sum;
  logic signed [TW-1:0]    o_t;
  logic signed [SAMPLE_WIDTH-1:0] o_val;
  logic                    mul_busy, mul_done;
  logic signed [HW-1:0]    prod;

  // Input sample moved to the internal 12-fraction-bit format.
  assign n_ext = {{(HW-SAMPLE_WIDTH-EXT_FRAC){in_sample_in[SAMPLE_WIDTH-1]}},
                  in_sample_in, {EXT_FRAC{1'b0}}};

  // Operand source select.
  always_comb begin
    case (cmd.uop.src)
      SRC_ZERO: src_val = '0;
      SRC_N:    src_val = n_r;
      SRC_R:    src_val = r_r;
      SRC_D:    src_val = d_r;
      SRC_H0:   src_val = h_r[0];
      SRC_H1:   src_val = h_r[1];
      SRC_H2:   src_val = h_r[2];
      default:  src_val = h_r[3];
    endcase
  end

  // Coefficient select; the weight is clamped to one.
  assign w_eff = (weight_r > W_ONE) ? W_ONE : weight_r;
  always_comb begin
    case (cmd.uop.bsel)
      B_B0:    b_val = b0_r;
      B_B1:    b_val = b1_r;
      B_B2:    b_val = b2_r;
      B_A1:    b_val = a1_r;
      B_A2:    b_val = a2_r;
      B_W:     b_val = CFG_W'(w_eff);
      B_WC:    b_val = CFG_W'(W_ONE - w_eff);
      default: b_val = '0;
    endcase
  end

  msf_mul #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .wfrac ((cmd.uop.bsel == B_W) || (cmd.uop.bsel == B_WC)),
    .a_in  (src_val),
    .b_in  (b_val),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  assign sts.mul_busy = mul_busy;
  assign sts.mul_done = mul_done;

  // Accumulator helpers: source extension, halving toward zero, saturation.
  assign acc_src = ACC_W'(src_val);
  assign acc_rnd = acc_r + $signed({{(ACC_W-1){1'b0}}, acc_r[ACC_W-1]});
  assign acc_sat = (acc_r > AMAX) ? AMAX[HW-1:0] :
                   ((acc_r < AMIN) ? AMIN[HW-1:0] : acc_r[HW-1:0]);

  // Median of the two previous samples and the new one.
  assign lo_v  = (h_r[0] > h_r[1]) ? h_r[1] : h_r[0];
  assign hi_v  = (h_r[0] > h_r[1]) ? h_r[0] : h_r[1];
  assign mid_v = (hi_v > n_r) ? n_r : hi_v;
  assign med_v = (lo_v > mid_v) ? lo_v : mid_v;

  // Register-file write for store, move and median.
  always_comb begin
    wr_en  = 1'b0;
    wr_val = acc_sat;
    if (cmd.exec) begin
      case (cmd.uop.op)
        OP_ST: begin
          wr_en  = 1'b1;
          wr_val = acc_sat;
        end
        OP_MOV: begin
          wr_en  = 1'b1;
          wr_val = src_val;
        end
        OP_MED: begin
          wr_en  = 1'b1;
          wr_val = med_v;
        end
        default: begin
          wr_en  = 1'b0;
        end
      endcase
    end
  end

  // Output rounding half up and saturation to the sample range.
  assign o_sum = {r_r[HW-1], r_r} + ORND;
  assign o_t   = o_sum[HW:EXT_FRAC];
  assign o_val = (o_t > SMAX) ? SMAX[SAMPLE_WIDTH-1:0] :
                 ((o_t < SMIN) ? SMIN[SAMPLE_WIDTH-1:0] : o_t[SAMPLE_WIDTH-1:0]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= '0;
      b1_r     <= '0;
      b2_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
      weight_r <= W_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_B0:     b0_r     <= cfg_data;
        IDX_B1:     b1_r     <= cfg_data;
        IDX_B2:     b2_r     <= cfg_data;
        IDX_A1:     a1_r     <= cfg_data;
        IDX_A2:     a2_r     <= cfg_data;
        IDX_WEIGHT: weight_r <= cfg_data[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // History: cleared by reset and by every mode write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) h_r[i] <= '0;
    end else if (cfg_we && (cfg_index == IDX_MODE)) begin
      for (int i = 0; i < 4; i++) h_r[i] <= '0;
    end else if (wr_en) begin
      case (cmd.uop.dst)
        DST_H0:  h_r[0] <= wr_val;
        DST_H1:  h_r[1] <= wr_val;
        DST_H2:  h_r[2] <= wr_val;
        DST_H3:  h_r[3] <= wr_val;
        default: begin
        end
      endcase
    end
  end

  // Sample, result, temporary, accumulator and output registers.
  always_ff @(posedge clk) begin
    if (cmd.n_load) begin
      n_r <= n_ext;
    end
    if (wr_en && (cmd.uop.dst == DST_R)) begin
      r_r <= wr_val;
    end
    if (wr_en && (cmd.uop.dst == DST_D)) begin
      d_r <= wr_val;
    end
    if (cmd.exec) begin
      case (cmd.uop.op)
        OP_LD:   acc_r <= acc_src;
        OP_ADD:  acc_r <= acc_r + acc_src;
        OP_SUB:  acc_r <= acc_r - acc_src;
        OP_HALF: acc_r <= acc_rnd >>> 1;
        default: begin
        end
      endcase
    end else if (cmd.mac_apply) begin
      if (cmd.uop.op == OP_MACS) begin
        acc_r <= acc_r - ACC_W'(prod);
      end else begin
        acc_r <= acc_r + ACC_W'(prod);
      end
    end
    if (cmd.out_load) begin
      out_r <= o_val;
    end
  end

  assign out_sample_out = out_r;

endmodule
`default_nettype wire

[rtl/msf_ctrl.sv]
// Controller: mode register, microprogram sequencer and handshake control.
`default_nettype none
module msf_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [msf_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [msf_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  input  wire msf_pkg::sts_t             sts,
  output msf_pkg::cmd_t                  cmd
);
  import msf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [MODE_W-1:0] mode_r;
  logic              out_valid_r, out_valid_nxt;
  uop_t              uop;
  logic              accept;
  logic              out_free;

  assign uop      = ucode(mode_r, step_r);
  assign accept   = in_valid && !in_stall;
  assign out_free = !(out_valid_r && out_stall);

  // Sequencer: one step per cycle; products wait for the multiplier and the last step for a free output.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.uop       = uop;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.n_load = 1'b1;
          step_nxt   = '0;
          state_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        unique case (uop.op) inside
          OP_MACA, OP_MACS: begin
            cmd.mul_start = 1'b1;
            state_nxt     = S_WAIT;
          end
          OP_END: begin
            if (out_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            cmd.exec = 1'b1;
            step_nxt = step_r + STEP_W'(1);
          end
        endcase
      end
      S_WAIT: begin
        if (sts.mul_done) begin
          cmd.mac_apply = 1'b1;
          step_nxt      = step_r + STEP_W'(1);
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on a load, cleared once the result is taken without out_stall.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      mode_r      <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == IDX_MODE)) begin
        mode_r <= cfg_data[MODE_W-1:0];
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
